### src/pds_pkg.sv
// Shared types and constants of the PLL divider search block.
package pds_pkg;

  localparam int unsigned TargetW  = 22;
  localparam int unsigned FreqW    = 18;
  localparam int unsigned ClkW     = 16;
  localparam int unsigned DivisorW = 11;
  localparam int unsigned MW       = 6;
  localparam int unsigned NW       = 9;
  localparam int unsigned PW       = 2;
  localparam int unsigned VcoOutW  = ClkW + NW;

  localparam logic [TargetW-1:0]  TARGET_MAX_KHZ  = 22'd180000;
  localparam logic [ClkW-1:0]     VCO_IN_MIN_KHZ  = 16'd1000;
  localparam logic [ClkW-1:0]     VCO_IN_MAX_KHZ  = 16'd2000;
  localparam logic [VcoOutW-1:0]  VCO_OUT_MIN_KHZ = 25'd100000;
  localparam logic [VcoOutW-1:0]  VCO_OUT_MAX_KHZ = 25'd432000;
  localparam logic [NW-1:0]       N_FIRST         = 9'd50;
  localparam logic [NW-1:0]       N_LAST          = 9'd432;
  localparam logic [MW-1:0]       M_FIRST         = 6'd2;
  localparam logic [MW-1:0]       M_LAST          = 6'd63;
  localparam logic [PW-1:0]       P_LAST          = 2'd3;

  // Reciprocal of three: floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for x below 2^18.
  localparam logic [FreqW-1:0]    RECIP3          = 18'd174763;
  localparam int unsigned         RECIP3_SHIFT    = 19;

  // Preset M: floor(x / 2000) == ((x >> 4) * RECIP125) >> RECIP125_SHIFT for 16-bit x.
  localparam logic [12:0]         RECIP125        = 13'd4195;
  localparam int unsigned         RECIP125_SHIFT  = 19;

  localparam logic [ClkW-1:0]     CLK_RESET_KHZ   = 16'd16000;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TARGET_HIGH = 2'd1,
    STATUS_PRESET_BAD  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    take_m;
    logic    take_vco;
    logic    mul;
    logic    eval;
    logic    n_inc;
    logic    m_inc;
    logic    fail;
    status_t fail_code;
    logic    publish;
  } cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic target_high;
    logic div_done;
    logic m_bad;
    logic vco_in_high;
    logic vco_in_low;
    logic vco_out_low;
    logic vco_out_high;
    logic n_last;
    logic m_last;
    logic p_last;
    logic exact;
    logic out_free;
  } stat_t;

endpackage

### src/pds_divider.sv
// Restoring divider, one quotient bit per cycle.
module pds_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pds_pkg::ClkW-1:0]      dividend,
  input  logic [pds_pkg::DivisorW-1:0]  divisor,
  output logic [pds_pkg::ClkW-1:0]      quotient,
  output logic                          done
);
  import pds_pkg::*;

  localparam int unsigned CntW = $clog2(ClkW + 1);

  logic [DivisorW-1:0] rem;
  logic [DivisorW-1:0] dvs;
  logic [ClkW-1:0]     quo;
  logic [CntW-1:0]     cnt;
  logic [DivisorW:0]   trial;
  logic                fits;

  assign trial    = {rem, quo[ClkW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CntW'(ClkW);
      done <= 1'b0;
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else begin
      done <= (cnt == CntW'(1));
      if (cnt != '0) begin
        cnt <= cnt - CntW'(1);
        rem <= fits ? DivisorW'(trial - {1'b0, dvs}) : trial[DivisorW-1:0];
        quo <= {quo[ClkW-2:0], fits};
      end
    end
  end

endmodule

### src/pds_datapath.sv
// Datapath: candidate arithmetic, best-candidate registers and the result register.
module pds_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  pds_pkg::cmd_t                cmd,
  output pds_pkg::stat_t               stat,
  input  logic [pds_pkg::ClkW-1:0]     input_clock_khz,
  input  logic [pds_pkg::TargetW-1:0]  target_khz,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [1:0]                   status,
  output logic [pds_pkg::FreqW-1:0]    achieved_khz,
  output logic [pds_pkg::MW-1:0]       div_m,
  output logic [pds_pkg::NW-1:0]       mult_n,
  output logic [pds_pkg::PW-1:0]       div_p_code
);
  import pds_pkg::*;

  logic [TargetW-1:0]   target;
  logic [MW-1:0]        m;
  logic [ClkW-1:0]      vco_in;
  logic [NW-1:0]        n;
  logic [VcoOutW-1:0]   vco_out;
  logic [PW-1:0]        p;
  logic [TargetW-1:0]   best_dist;
  logic [FreqW-1:0]     best_f;
  logic [MW-1:0]        best_m;
  logic [NW-1:0]        best_n;
  logic [PW-1:0]        best_p;
  status_t              res_status;

  logic [ClkW-1:0]      quotient;
  logic [DivisorW-1:0]  divisor;
  logic [ClkW+8:0]      preset_prod;
  logic [MW-1:0]        preset_m;
  logic [FreqW-1:0]     half;
  logic [2*FreqW-1:0]   third_prod;
  logic [FreqW-1:0]     f;
  logic [TargetW-1:0]   f_ext;
  logic [TargetW-1:0]   cand_gap;

  assign divisor = DivisorW'(m);

  pds_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (input_clock_khz),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (stat.div_done)
  );

  // The preset M never exceeds 32 for a 16-bit clock, so six bits hold it.
  assign preset_prod = input_clock_khz[ClkW-1:4] * RECIP125;
  assign preset_m    = MW'(preset_prod >> RECIP125_SHIFT);

  // Only VCO outputs inside the legal window are evaluated, so 19 bits carry them.
  assign half       = vco_out[FreqW:1];
  assign third_prod = half * RECIP3;

  always_comb begin
    unique case (p)
      2'd0:    f = half;
      2'd1:    f = half >> 1;
      2'd2:    f = FreqW'(third_prod >> RECIP3_SHIFT);
      default: f = half >> 2;
    endcase
  end

  assign f_ext    = TargetW'(f);
  assign cand_gap = (target > f_ext) ? (target - f_ext) : (f_ext - target);

  assign stat.target_high  = target > TARGET_MAX_KHZ;
  assign stat.m_bad        = preset_m < M_FIRST;
  assign stat.vco_in_high  = vco_in > VCO_IN_MAX_KHZ;
  assign stat.vco_in_low   = vco_in < VCO_IN_MIN_KHZ;
  assign stat.vco_out_low  = vco_out < VCO_OUT_MIN_KHZ;
  assign stat.vco_out_high = vco_out > VCO_OUT_MAX_KHZ;
  assign stat.n_last       = n == N_LAST;
  assign stat.m_last       = m == M_LAST;
  assign stat.p_last       = p == P_LAST;
  assign stat.exact        = best_dist == '0;
  assign stat.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target     <= target_khz;
      best_dist  <= target_khz;
      best_f     <= '0;
      best_m     <= '0;
      best_n     <= '0;
      best_p     <= '0;
      m          <= M_FIRST;
      res_status <= STATUS_OK;
    end
    if (cmd.take_m) begin
      m      <= preset_m;
      best_m <= preset_m;
    end
    if (cmd.take_vco) begin
      vco_in <= quotient;
      n      <= N_FIRST;
    end
    if (cmd.mul) begin
      vco_out <= vco_in * n;
      p       <= '0;
    end
    if (cmd.eval) begin
      p <= p + PW'(1);
      if (cand_gap < best_dist) begin
        best_dist <= cand_gap;
        best_f    <= f;
        best_m    <= m;
        best_n    <= n;
        best_p    <= p;
      end
    end
    if (cmd.n_inc) n <= n + NW'(1);
    if (cmd.m_inc) m <= m + MW'(1);
    if (cmd.fail) begin
      res_status <= cmd.fail_code;
      best_f     <= '0;
      best_m     <= '0;
      best_n     <= '0;
      best_p     <= '0;
    end
  end

  // Result register: a finished search waits here while a new one may start.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status       <= res_status;
      achieved_khz <= best_f;
      div_m        <= best_m;
      mult_n       <= best_n;
      div_p_code   <= best_p;
    end
  end

endmodule

### src/pds_ctrl.sv
// Controller state machine that sequences the M, N and P search.
module pds_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           preset_divider_mode,
  input  pds_pkg::stat_t stat,
  output pds_pkg::cmd_t  cmd
);
  import pds_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_PDIV   = 11'b00000000100,
    S_MSTART = 11'b00000001000,
    S_MDIV   = 11'b00000010000,
    S_MCHK   = 11'b00000100000,
    S_NMUL   = 11'b00001000000,
    S_NCHK   = 11'b00010000000,
    S_PEVAL  = 11'b00100000000,
    S_ENDM   = 11'b01000000000,
    S_FINISH = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    cmd.fail_code = STATUS_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.target_high) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = STATUS_TARGET_HIGH;
          state_next    = S_FINISH;
        end else if (preset_divider_mode) begin
          state_next = S_PDIV;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_MDIV;
        end
      end
      S_PDIV: begin
        if (stat.m_bad) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = STATUS_PRESET_BAD;
          state_next    = S_FINISH;
        end else begin
          cmd.take_m = 1'b1;
          state_next = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_MDIV;
      end
      S_MDIV: begin
        if (stat.div_done) begin
          cmd.take_vco = 1'b1;
          state_next   = S_MCHK;
        end
      end
      S_MCHK: begin
        if (!preset_divider_mode && stat.vco_in_high) state_next = S_ENDM;
        else if (!preset_divider_mode && stat.vco_in_low) state_next = S_FINISH;
        else state_next = S_NMUL;
      end
      S_NMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_NCHK;
      end
      S_NCHK: begin
        if (stat.vco_out_high) begin
          state_next = S_ENDM;
        end else if (stat.vco_out_low) begin
          if (stat.n_last) begin
            state_next = S_ENDM;
          end else begin
            cmd.n_inc  = 1'b1;
            state_next = S_NMUL;
          end
        end else begin
          state_next = S_PEVAL;
        end
      end
      S_PEVAL: begin
        if (stat.exact) begin
          state_next = S_FINISH;
        end else begin
          cmd.eval = 1'b1;
          if (stat.p_last) begin
            if (stat.n_last) begin
              state_next = S_ENDM;
            end else begin
              cmd.n_inc  = 1'b1;
              state_next = S_NMUL;
            end
          end
        end
      end
      S_ENDM: begin
        if (preset_divider_mode || stat.m_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.m_inc  = 1'b1;
          state_next = S_MSTART;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### src/pll_divider_search_top.sv
// Top level of the PLL divider search block: configuration registers and unit wiring.
//
//   Channel   Handshake          Beat contents
//   input     in_valid/in_stall  target_khz
//   output    out_valid/out_stall status, achieved_khz, div_m, mult_n, div_p_code
//   config    APB (psel/penable) input_clock_khz at 0x0, preset_divider_mode at 0x4
//
// One input beat is searched at a time; the input is stalled from acceptance until the
// result has been placed in the output register. Each M uses the shared restoring divider,
// each N a multiply and a range check plus an evaluation of the four P codes when its VCO
// output is legal, and an exact hit or an error ends the search early. Reset is synchronous
// and returns the registers to 16000 kHz and search mode. A stalled result waits in the
// output register while the next beat may already be accepted and searched.
module pll_divider_search_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [21:0] target_khz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [17:0] achieved_khz,
  output logic [5:0]  div_m,
  output logic [8:0]  mult_n,
  output logic [1:0]  div_p_code
);
  import pds_pkg::*;

  logic [ClkW-1:0] input_clock_khz;
  logic            preset_divider_mode;
  logic            cfg_write;
  cmd_t            cmd;
  stat_t           stat;

  // Registers are decoded on address bit 2 alone; the low bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[2] ? {31'b0, preset_divider_mode} : {16'b0, input_clock_khz};

  always_ff @(posedge clk) begin
    if (rst) begin
      input_clock_khz     <= CLK_RESET_KHZ;
      preset_divider_mode <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2]) preset_divider_mode <= pwdata[0];
      else          input_clock_khz     <= pwdata[ClkW-1:0];
    end
  end

  pds_ctrl u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .preset_divider_mode (preset_divider_mode),
    .stat                (stat),
    .cmd                 (cmd)
  );

  pds_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .input_clock_khz (input_clock_khz),
    .target_khz      (target_khz),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .status          (status),
    .achieved_khz    (achieved_khz),
    .div_m           (div_m),
    .mult_n          (mult_n),
    .div_p_code      (div_p_code)
  );

endmodule
